>>> sv/mtf_pkg.sv
// Shared types and constants for the move-to-front key set.
package mtf_pkg;

   localparam int CAPACITY  = 16;
   localparam int KEY_BITS  = 32;
   localparam int SLOT_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_GET    = 2'd1;
   localparam logic [1:0] OP_LIST   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_DUP  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]          op;
      logic [KEY_BITS-1:0] key;
   } cmd_type;

endpackage

>>> sv/mtf_front.sv
// Front end: accepts requests, drops unused op codes, queues commands.
module mtf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [31:0]       req_key,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output mtf_pkg::cmd_type  cmd
);

   mtf_pkg::cmd_type                q_ff [mtf_pkg::QDEPTH];
   logic [mtf_pkg::QPTR_BITS-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [mtf_pkg::QCNT_BITS-1:0]   n_ff, n_in;
   logic                            push, pop;

   assign req_stall = (n_ff == mtf_pkg::QCNT_BITS'(mtf_pkg::QDEPTH));
   assign push      = req_valid && !req_stall && (req_op != mtf_pkg::OP_UNUSED);
   assign cmd_valid = (n_ff != '0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (push)
         wp_in = (wp_ff == mtf_pkg::QPTR_BITS'(mtf_pkg::QDEPTH - 1)) ? '0 :
                 wp_ff + mtf_pkg::QPTR_BITS'(1);
      if (pop)
         rp_in = (rp_ff == mtf_pkg::QPTR_BITS'(mtf_pkg::QDEPTH - 1)) ? '0 :
                 rp_ff + mtf_pkg::QPTR_BITS'(1);
      n_in  = n_ff + mtf_pkg::QCNT_BITS'(push) - mtf_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         n_ff  <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
      if (push) begin
         q_ff[wp_ff].op  <= req_op;
         q_ff[wp_ff].key <= mtf_pkg::KEY_BITS'(req_key);
      end
   end

endmodule

>>> sv/mtf_back.sv
// Back end: key compare, order update and list walk with output register.
module mtf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  mtf_pkg::cmd_type  cmd,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_value,
   output logic [4:0]        rsp_count,
   output logic              rsp_last
);

   localparam int SB = mtf_pkg::SLOT_BITS;
   localparam int CB = mtf_pkg::CNT_BITS;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_LIST = 3'b100
   } state_type;

   state_type                    state_ff, state_in;
   logic [mtf_pkg::KEY_BITS-1:0] keys_ff  [mtf_pkg::CAPACITY];
   logic [SB-1:0]                order_ff [mtf_pkg::CAPACITY];
   logic [CB-1:0]                cnt_ff, cnt_in;
   mtf_pkg::cmd_type             cur_ff, cur_in;
   logic [CB-1:0]                pos_ff, pos_in;
   logic                         ov_ff, ov_in;
   logic [1:0]                   os_ff, os_in;
   logic [31:0]                  oval_ff, oval_in;
   logic [4:0]                   ocnt_ff, ocnt_in;
   logic                         olast_ff, olast_in;

   logic                         hit;
   logic [SB-1:0]                hslot;
   logic [mtf_pkg::CAPACITY-1:0] shift_en;
   logic                         out_free;
   logic                         add_we, mtf_we;

   assign out_free  = !ov_ff || !rsp_stall;
   assign cmd_take  = (state_ff == S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_status = os_ff;
   assign rsp_value  = oval_ff;
   assign rsp_count  = ocnt_ff;
   assign rsp_last   = olast_ff;

   // parallel compare over occupied slots
   always_comb begin
      logic seen;
      hit   = 1'b0;
      hslot = '0;
      for (int i = 0; i < mtf_pkg::CAPACITY; i++) begin
         if (CB'(i) < cnt_ff && keys_ff[i] == cur_ff.key) begin
            hit   = 1'b1;
            hslot = SB'(i);
         end
      end
      // positions at or before the one holding the hit slot move back by one
      seen = 1'b0;
      for (int p = mtf_pkg::CAPACITY - 1; p >= 0; p--) begin
         seen        = seen | ((CB'(p) < cnt_ff) && (order_ff[p] == hslot));
         shift_en[p] = seen;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (cmd_valid) state_in = S_IDLE == S_IDLE ? S_EXEC : S_EXEC;
         S_EXEC: if (out_free) state_in =
                    (cur_ff.op == mtf_pkg::OP_LIST && cnt_ff > CB'(1)) ? S_LIST : S_IDLE;
         S_LIST: if (out_free && pos_ff == cnt_ff - CB'(1)) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cur_in   = cur_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      ov_in    = ov_ff && rsp_stall;
      os_in    = os_ff;
      oval_in  = oval_ff;
      ocnt_in  = ocnt_ff;
      olast_in = olast_ff;
      add_we   = 1'b0;
      mtf_we   = 1'b0;
      unique case (state_ff)
         S_IDLE: if (cmd_valid) begin
            cur_in = cmd;
            pos_in = '0;
         end
         S_EXEC: if (out_free) begin
            ov_in    = 1'b1;
            ocnt_in  = 5'(cnt_ff);
            olast_in = 1'b1;
            unique case (cur_ff.op)
               mtf_pkg::OP_ADD: begin
                  oval_in = 32'(cur_ff.key);
                  if (hit) os_in = mtf_pkg::ST_DUP;
                  else if (cnt_ff == CB'(mtf_pkg::CAPACITY)) os_in = mtf_pkg::ST_FULL;
                  else begin
                     os_in   = mtf_pkg::ST_DONE;
                     add_we  = 1'b1;
                     cnt_in  = cnt_ff + CB'(1);
                     ocnt_in = 5'(cnt_ff + CB'(1));
                  end
               end
               mtf_pkg::OP_GET: begin
                  os_in   = hit ? mtf_pkg::ST_DONE : mtf_pkg::ST_NONE;
                  oval_in = hit ? 32'(keys_ff[hslot]) : 32'd0;
                  mtf_we  = hit;
               end
               default: begin
                  // list: first word here, rest from S_LIST
                  if (cnt_ff == '0) begin
                     os_in   = mtf_pkg::ST_NONE;
                     oval_in = 32'd0;
                  end else begin
                     os_in    = mtf_pkg::ST_DONE;
                     oval_in  = 32'(keys_ff[order_ff[0]]);
                     olast_in = (cnt_ff == CB'(1));
                     pos_in   = CB'(1);
                  end
               end
            endcase
         end
         S_LIST: if (out_free) begin
            ov_in    = 1'b1;
            os_in    = mtf_pkg::ST_DONE;
            oval_in  = 32'(keys_ff[order_ff[pos_ff[SB-1:0]]]);
            ocnt_in  = 5'(cnt_ff);
            olast_in = (pos_ff == cnt_ff - CB'(1));
            pos_in   = pos_ff + CB'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
      end
      cur_ff   <= cur_in;
      pos_ff   <= pos_in;
      os_ff    <= os_in;
      oval_ff  <= oval_in;
      ocnt_ff  <= ocnt_in;
      olast_ff <= olast_in;
      if (add_we)
         keys_ff[cnt_ff[SB-1:0]] <= cur_ff.key;
      if (mtf_we) begin
         order_ff[0] <= hslot;
         for (int p = 1; p < mtf_pkg::CAPACITY; p++)
            if (shift_en[p])
               order_ff[p] <= order_ff[p-1];
      end else if (add_we) begin
         order_ff[cnt_ff[SB-1:0]] <= cnt_ff[SB-1:0];
      end
   end

endmodule

>>> sv/move_to_front_key_set_unit.sv
// Top level of the move-to-front key set.
//  channel | dir | ports
//  req     | in  | req_valid, req_stall, req_op, req_key
//  rsp     | out | rsp_valid, rsp_stall, rsp_status, rsp_value, rsp_count, rsp_last
// In the back end an add or get loads the command in S_IDLE, then compares and updates in S_EXEC.
// A list gives one word per cycle from the order table unless results are stalled; an empty set gives one word.
// Synchronous reset empties the set; key and order tables are not cleared.
// A two-entry command queue lets requests arrive while results are stalled.
module move_to_front_key_set_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_value,
   output logic [4:0]  rsp_count,
   output logic        rsp_last
);

   logic             cmd_valid, cmd_take;
   mtf_pkg::cmd_type cmd;

   mtf_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_key,
      .cmd_valid, .cmd_take, .cmd
   );

   mtf_back u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_value, .rsp_count, .rsp_last
   );

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= 5'(mtf_pkg::CAPACITY))
      else $error("count above capacity");
   a_none_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mtf_pkg::ST_NONE |-> rsp_value == 32'd0 && rsp_last)
      else $error("not-found word malformed");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("stalled word changed");
`endif

endmodule
